[hdl/pixel_stack_median_defines.svh]
// Assertion macros for the pixel stack median block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PIXEL_STACK_MEDIAN_DEFINES_SVH
`define PIXEL_STACK_MEDIAN_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixel_stack_median assertion failed");

// Next-cycle implication, disabled while in reset.
`define PSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pixel_stack_median assertion failed");

`endif

[hdl/psm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the pixel stack median block.
// No dependencies.
package psm_pkg;

  localparam int MEDIAN_W  = 16;
  localparam int DEPTH_W   = 6;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd30;

  // Register index, decoded from paddr[2]
  localparam logic REG_STACK_DEPTH = 1'b0;

  // Per-cell control from the top level
  typedef struct packed {
    logic load;      // a sample is inserted this cycle
    logic occupied;  // cell holds a sample of the current pixel
    logic tail;      // cell is the first free slot
  } cell_ctl_t;

endpackage

[hdl/psm_ifs.sv]
`timescale 1ns / 1ps
// Stream interfaces for samples in and medians out.
// Depends on psm_pkg.
interface psm_sample_if #(
  parameter int W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface psm_median_if
  import psm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

[hdl/pixel_stack_median.sv]
`timescale 1ns / 1ps
// Pixel stack median: top level. Depends on psm_pkg, psm_ifs, psm_cell, psm_cfg
// and pixel_stack_median_defines.svh.
//
// Takes one sample per cycle. Samples are kept sorted in a row of MAX_FRAMES
// cells: on each transaction every cell compares its value with the new sample
// at once and the larger ones step one cell to the right. When the count held
// reaches stack_depth (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES),
// the two middle values are latched into the middle-pair stage and the median
// leaves through the output register.
// One finished median may wait on a stalled output while the next pixel fills;
// input stalls only when a second median is ready and the first is not taken.
module pixel_stack_median
  import psm_pkg::*;
#(
  parameter int MAX_FRAMES  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  psm_sample_if.sink          sample_i,
  psm_median_if.source        median_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

`include "pixel_stack_median_defines.svh"

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int CMPW = 8;

  logic [DEPTH_W-1:0] stack_depth;

  psm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .stack_depth_o (stack_depth)
  );

  // Cell chain
  logic [CW-1:0]          fill_q, fill_d;
  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] val   [MAX_FRAMES];
  logic [SAMPLE_BITS-1:0] val_d [MAX_FRAMES];
  logic                   gt    [MAX_FRAMES];
  cell_ctl_t              ctl   [MAX_FRAMES];

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign ctl[i].load     = in_acc;
    assign ctl[i].occupied = (CW'(i) < fill_q);
    assign ctl[i].tail     = (CW'(i) == fill_q);

    if (i == 0) begin : g_head
      psm_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk_i,
        .ctl_i      (ctl[i]),
        .sample_i   (sample_i.sample),
        .left_val_i ('0),
        .left_gt_i  (1'b0),
        .val_o      (val[i]),
        .val_d_o    (val_d[i]),
        .gt_o       (gt[i])
      );
    end else begin : g_body
      psm_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk_i,
        .ctl_i      (ctl[i]),
        .sample_i   (sample_i.sample),
        .left_val_i (val[i-1]),
        .left_gt_i  (gt[i-1]),
        .val_o      (val[i]),
        .val_d_o    (val_d[i]),
        .gt_o       (gt[i])
      );
    end
  end

  // Count after this insert, and whether it closes the pixel
  logic [CW-1:0]   n_new;
  logic [CMPW-1:0] eff_depth;
  logic            finish;
  logic [IW-1:0]   hi_idx, lo_idx;

  assign n_new = fill_q + CW'(1);

  always_comb begin
    if (stack_depth == '0) begin
      eff_depth = CMPW'(1);
    end else if (CMPW'(stack_depth) > CMPW'(MAX_FRAMES)) begin
      eff_depth = CMPW'(MAX_FRAMES);
    end else begin
      eff_depth = CMPW'(stack_depth);
    end
  end

  assign finish = CMPW'(n_new) >= eff_depth;
  assign hi_idx = IW'(n_new >> 1);
  assign lo_idx = n_new[0] ? hi_idx : hi_idx - IW'(1);

  always_comb begin
    fill_d = fill_q;
    if (in_acc) begin
      fill_d = finish ? '0 : n_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Middle-pair stage, then output register
  logic                   s1_valid_q, s1_valid_d, s1_adv;
  logic [SAMPLE_BITS-1:0] lo_q, hi_q;
  logic                   out_valid_q, out_valid_d;
  logic [MEDIAN_W-1:0]    med_q;
  logic [SAMPLE_BITS:0]   pair_sum;

  assign s1_adv          = s1_valid_q && (!out_valid_q || median_o.ready);
  assign sample_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc          = sample_i.valid && sample_i.ready;
  assign pair_sum        = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc && finish) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && finish) begin
      lo_q <= val_d[lo_idx];
      hi_q <= val_d[hi_idx];
    end
    if (s1_adv) begin
      med_q <= MEDIAN_W'(pair_sum[SAMPLE_BITS:1]);
    end
  end

  assign median_o.valid  = out_valid_q;
  assign median_o.median = med_q;

  // Held samples stay in ascending order
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < MAX_FRAMES - 1; i++) begin
      if ((CW'(i + 1) < fill_q) && (val[i] > val[i+1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `PSM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q < CW'(MAX_FRAMES))
  `PSM_ASSERT_IMPL(a_sorted, 1'b1, sorted_ok)
  `PSM_ASSERT_NEXT(a_finish_clears, in_acc && finish, fill_q == '0 && s1_valid_q)

endmodule

[hdl/psm_cell.sv]
`timescale 1ns / 1ps
// One slot of the insertion-sort chain: holds a sample and shifts right on insert.
// Depends on psm_pkg.
module psm_cell
  import psm_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  cell_ctl_t    ctl_i,
  input  logic [W-1:0] sample_i,
  input  logic [W-1:0] left_val_i,
  input  logic         left_gt_i,
  output logic [W-1:0] val_o,
  output logic [W-1:0] val_d_o,
  output logic         gt_o
);

  logic [W-1:0] val_q, val_d;

  assign gt_o = ctl_i.occupied && (val_q > sample_i);

  always_comb begin
    val_d = val_q;
    if (ctl_i.load) begin
      // left neighbor is larger than the sample: its value moves in
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || ctl_i.tail) begin
        val_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

[hdl/psm_cfg.sv]
`timescale 1ns / 1ps
// APB-style register port holding stack_depth.
// Depends on psm_pkg.
module psm_cfg
  import psm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [DEPTH_W-1:0] stack_depth_o
);

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_STACK_DEPTH);

  always_comb begin
    depth_d = depth_q;
    if (psel && penable && pwrite && hit) begin
      depth_d = pwdata[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign prdata        = hit ? PDATA_W'(depth_q) : '0;
  assign stack_depth_o = depth_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pixel_stack_median: streams samples, programs the stack
// depth over APB and compares every median against an in-bench sorted-insert predictor.
// Depends on psm_pkg, psm_ifs and the pixel_stack_median RTL.
module tb_top
  import psm_pkg::*;
;

  localparam int STACK_MAX       = 32;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 12;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SAMPLE_TARGET   = 1000;
  localparam int MAX_REPORTS     = 10;
  localparam logic [PADDR_W-1:0] DEPTH_ADDR = {REG_STACK_DEPTH, 2'b00};

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_e;

  // Tracks held samples per pixel and the medians still owed by the block.
  class median_scoreboard;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [MEDIAN_W-1:0] held[$];
    logic [MEDIAN_W-1:0] expected_medians[$];
    int unsigned         mismatches;

    function new();
      depth_reg  = DEPTH_RESET;
      mismatches = 0;
    endfunction

    function void set_depth(logic [DEPTH_W-1:0] d);
      depth_reg = d;
    endfunction

    function void note_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_val, got_val);
    endfunction

    function void note_sample(logic [MEDIAN_W-1:0] s);
      int              pos;
      int              n;
      int              lim;
      logic [MEDIAN_W:0] pair_sum;
      pos = held.size();
      // equal samples go after the ones already held
      while (pos > 0 && held[pos-1] > s) pos--;
      held.insert(pos, s);
      lim = (depth_reg == '0) ? 1 : ((int'(depth_reg) > STACK_MAX) ? STACK_MAX : int'(depth_reg));
      if (held.size() >= lim) begin
        n = held.size();
        if (n % 2 == 1) begin
          expected_medians.insert(expected_medians.size(), held[n/2]);
        end else begin
          pair_sum = {1'b0, held[n/2-1]} + {1'b0, held[n/2]};
          expected_medians.insert(expected_medians.size(), pair_sum[MEDIAN_W:1]);
        end
        held.delete();
      end
    endfunction

    function void check_median(logic [MEDIAN_W-1:0] got);
      logic [MEDIAN_W-1:0] exp_med;
      if (expected_medians.size() == 0) begin
        note_mismatch("unexpected median", '0, got);
        return;
      end
      exp_med = expected_medians.pop_front();
      if (got !== exp_med) note_mismatch("median", exp_med, got);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  psm_sample_if #(.W(MEDIAN_W)) sample_if ();
  psm_median_if                 median_if ();

  pixel_stack_median #(
    .MAX_FRAMES  (STACK_MAX),
    .SAMPLE_BITS (MEDIAN_W)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .median_o (median_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  median_scoreboard sb = new();

  rx_mode_e    rx_mode      = RX_ALWAYS;
  logic        hold_request = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 0;
  int          idle_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: own stall pattern, plus one long hold-off on request.
  initial begin
    logic [7:0] rx_pattern;
    rx_pattern = 8'b1011_0110;
    median_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        median_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  median_if.ready <= 1'b1;
          RX_RANDOM:  median_if.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: median_if.ready <= rx_pattern[0];
          RX_SLOW:    median_if.ready <= ($urandom_range(0, 3) == 0);
          default:    median_if.ready <= 1'b1;
        endcase
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && median_if.valid && median_if.ready) sb.check_median(median_if.median);
  end

  // Watchdog: cycles with no transaction on any port.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (median_if.valid && median_if.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [MEDIAN_W-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid  <= 1'b1;
    sample_if.sample <= s;
    do @(posedge clk_i); while (!sample_if.ready);
    sb.note_sample(s);
  endtask

  // Let every owed median out, then give an in-flight insert time to land.
  task automatic drain_medians();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DEPTH_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_depth(value[DEPTH_W-1:0]);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DEPTH_W-1:0] !== value[DEPTH_W-1:0])
      sb.note_mismatch("stack_depth readback", value[DEPTH_W-1:0], prdata[DEPTH_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int unsigned         sent;
    int unsigned         n;
    logic [DEPTH_W-1:0]  d;
    logic [PDATA_W-1:0]  value;
    logic [MEDIAN_W-1:0] s;

    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    sample_if.valid  <= 1'b0;
    sample_if.sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // depth zero acts as one; upper write bits are junk
    write_depth(32'hFFFF_FFC0);
    send_sample('0);
    send_sample('1);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    drain_medians();

    // even count with both middles at full scale: sum needs the extra bit
    write_depth(2);
    send_sample('1);
    send_sample('1);
    send_sample(16'h0000);
    send_sample(16'h0001);
    drain_medians();

    // equal samples
    write_depth(3);
    send_sample(16'h0007);
    send_sample(16'h0007);
    send_sample(16'h0003);
    drain_medians();

    // depth lowered while a pixel is half full
    write_depth(10);
    send_sample(16'd9);
    send_sample(16'd1);
    send_sample(16'd8);
    send_sample(16'd2);
    send_sample(16'd5);
    drain_medians();
    write_depth(3);
    send_sample(16'd4);
    drain_medians();

    // back-pressure: receiver holds off while the sender keeps pushing
    write_depth(1);
    gap_max      = 0;
    rx_mode      = RX_ALWAYS;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(16'($urandom));
    drain_medians();

    sent = 0;
    while (sent < SAMPLE_TARGET) begin
      case ($urandom_range(0, 11))
        0:       d = '0;
        1:       d = 6'd63;
        2:       d = 6'd32;
        3:       d = 6'd33;
        4:       d = DEPTH_W'($urandom_range(9, 31));
        default: d = DEPTH_W'($urandom_range(1, 8));
      endcase
      value = $urandom;
      value[DEPTH_W-1:0] = d;
      write_depth(value);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      n = $urandom_range(1, 70);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 7))
          0:       s = '0;
          1:       s = '1;
          2:       s = MEDIAN_W'($urandom_range(0, 3));
          3:       s = '1 - MEDIAN_W'($urandom_range(0, 3));
          default: s = MEDIAN_W'($urandom);
        endcase
        send_sample(s);
      end
      sent += n;
      drain_medians();
    end

    rx_mode = RX_ALWAYS;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_medians.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[pixel_stack_median.f]
+incdir+hdl
hdl/psm_pkg.sv
hdl/psm_ifs.sv
hdl/psm_cell.sv
hdl/psm_cfg.sv
hdl/pixel_stack_median.sv
verif/tb_top.sv
